// ===== rtl/gsa_pkg.sv =====
package gsa_pkg;

  localparam int unsigned SlotCountDefault = 64;
  localparam int unsigned IndexWidth       = 6;
  localparam int unsigned GenWidth         = 32;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_FINISH  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                 mode;
    logic [IndexWidth-1:0] slot_index;
    logic [GenWidth-1:0]   generation;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [IndexWidth-1:0] handle_index;
    logic [GenWidth-1:0]   handle_generation;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

// ===== rtl/gsa_free_stack.sv =====
module gsa_free_stack #(
  parameter int unsigned SLOT_COUNT = gsa_pkg::SlotCountDefault,
  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gsa_pkg::stack_op_t         op_i,
  input  logic [IW-1:0]              push_idx_i,
  input  logic [gsa_pkg::GenWidth-1:0] push_gen_i,
  output logic                       empty_o,
  output logic [IW-1:0]              top_idx_o,
  output logic [gsa_pkg::GenWidth-1:0] top_gen_o
);
  import gsa_pkg::*;

  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  logic [IW-1:0]       idx_mem [SLOT_COUNT];
  logic [GenWidth-1:0] gen_mem [SLOT_COUNT];

  logic [CW-1:0]       depth_q, depth_d;
  logic                push_eff, pop_eff;
  logic [CW-1:0]       below_d;
  logic [IW-1:0]       raddr;
  logic [IW-1:0]       rd_idx_q;
  logic [GenWidth-1:0] rd_gen_q;
  logic                fwd_q;
  logic [IW-1:0]       fwd_idx_q;
  logic [GenWidth-1:0] fwd_gen_q;

  assign push_eff = op_i.push && (32'(depth_q) < SLOT_COUNT);
  assign pop_eff  = op_i.pop && (depth_q != '0);

  always_comb begin
    depth_d = depth_q;
    if (push_eff) begin
      depth_d = depth_q + CW'(1);
    end else if (pop_eff) begin
      depth_d = depth_q - CW'(1);
    end
  end

  // top entry after this update; a push lands on top and is forwarded
  assign below_d = depth_d - CW'(1);
  assign raddr   = below_d[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_eff) begin
      idx_mem[depth_q[IW-1:0]] <= push_idx_i;
      gen_mem[depth_q[IW-1:0]] <= push_gen_i;
    end
    rd_idx_q  <= idx_mem[raddr];
    rd_gen_q  <= gen_mem[raddr];
    fwd_idx_q <= push_idx_i;
    fwd_gen_q <= push_gen_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      fwd_q   <= push_eff;
    end
  end

  assign empty_o   = (depth_q == '0);
  assign top_idx_o = fwd_q ? fwd_idx_q : rd_idx_q;
  assign top_gen_o = fwd_q ? fwd_gen_q : rd_gen_q;

endmodule

// ===== rtl/generational_slot_allocator.sv =====
// Slot allocator with generation-tagged handles. One request is taken per
// clock (busy_o stays low); its result appears on rsp_o with done_o high
// for exactly one cycle, once the request has passed through the request
// register and then the result register. The receiver cannot stall and
// must take each result in that cycle. Slot generations and the free
// stack live in memories read at request time; results from the request
// in flight are forwarded. No clearing pass is needed after reset.
module generational_slot_allocator #(
  parameter int unsigned SLOT_COUNT = gsa_pkg::SlotCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  gsa_pkg::req_t req_i,
  output logic          done_o,
  output gsa_pkg::rsp_t rsp_o
);
  import gsa_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  logic [GenWidth-1:0] gen_mem [SLOT_COUNT];

  logic                valid_q;
  req_t                req_q;
  logic [CW-1:0]       created_q, created_d;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic                done_q;
  rsp_t                rsp_q, rsp_d;

  logic [GenWidth-1:0] gen_rd_q, fwd_gen_q, gen_cur;
  logic                fwd_q;
  logic [IW-1:0]       gen_raddr;
  logic                gen_we;
  logic [IW-1:0]       gen_waddr;
  logic [GenWidth-1:0] gen_wdata;

  stack_op_t           op;
  logic                stk_empty;
  logic [IW-1:0]       top_idx;
  logic [GenWidth-1:0] top_gen;

  logic [IW-1:0]       ia;
  logic                idx_ok, act, gen_match;
  logic                got;
  logic [IW-1:0]       s;
  logic [GenWidth-1:0] ng;

  assign busy_o    = 1'b0;
  assign gen_raddr = IW'(req_i.slot_index);

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    gen_rd_q  <= gen_mem[gen_raddr];
    fwd_gen_q <= gen_wdata;
    if (start_i) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      fwd_q     <= 1'b0;
      created_q <= '0;
      active_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      valid_q   <= start_i;
      fwd_q     <= gen_we && (gen_waddr == gen_raddr);
      created_q <= created_d;
      active_q  <= active_d;
      done_q    <= valid_q;
    end
  end

  assign gen_cur   = fwd_q ? fwd_gen_q : gen_rd_q;
  assign ia        = IW'(req_q.slot_index);
  assign idx_ok    = (32'(req_q.slot_index) < SLOT_COUNT) &&
                     (32'(req_q.slot_index) < 32'(created_q));
  assign act       = idx_ok && active_q[ia];
  assign gen_match = (gen_cur == req_q.generation);

  always_comb begin
    rsp_d.status            = ST_OK;
    rsp_d.handle_index      = req_q.slot_index;
    rsp_d.handle_generation = req_q.generation;
    op        = '0;
    created_d = created_q;
    active_d  = active_q;
    gen_we    = 1'b0;
    got       = 1'b0;
    s         = top_idx;
    ng        = top_gen + GenWidth'(1);
    case (req_q.mode)
      MODE_ALLOC: begin
        if (!stk_empty) begin
          op.pop = valid_q;
          got    = 1'b1;
        end else if (32'(created_q) < SLOT_COUNT) begin
          s         = IW'(created_q);
          ng        = GenWidth'(1);
          created_d = valid_q ? created_q + CW'(1) : created_q;
          got       = 1'b1;
        end
        if (got) begin
          gen_we                  = valid_q;
          active_d[s]             = valid_q | active_q[s];
          rsp_d.handle_index      = IndexWidth'(s);
          rsp_d.handle_generation = ng;
        end else begin
          rsp_d.status            = ST_FULL;
          rsp_d.handle_index      = '0;
          rsp_d.handle_generation = '0;
        end
      end
      MODE_RELEASE: begin
        if (act && gen_match) begin
          op.push = valid_q;
        end else begin
          rsp_d.status = ST_INVALID;
        end
      end
      MODE_QUERY: begin
        if (!(act && gen_match)) begin
          rsp_d.status = ST_INVALID;
        end
      end
      MODE_FINISH: begin
        if (act) begin
          op.push = valid_q;
        end else begin
          rsp_d.status = ST_INVALID;
        end
      end
      default: begin
        rsp_d.status = ST_INVALID;
      end
    endcase
    if (op.push) begin
      active_d[ia] = 1'b0;
    end
  end

  assign gen_waddr = s;
  assign gen_wdata = ng;

  gsa_free_stack #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .push_idx_i (ia),
    .push_gen_i (gen_cur),
    .empty_o    (stk_empty),
    .top_idx_o  (top_idx),
    .top_gen_o  (top_gen)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
